// File: src/gbba_pkg.sv
// Shared constants, types and helpers of the grouped bitmap block allocator.
package gbba_pkg;

   localparam int DEF_BLOCKS_PER_GROUP = 256;
   localparam int DEF_GROUPS           = 16;
   localparam int WORD_BITS            = 32;
   localparam int BIT_W                = 5;

   localparam int BLK_W      = 12;
   localparam int INODE_W    = 20;
   localparam int IPG_W      = 16;
   localparam int TBLK_W     = 13;
   localparam int GRP_REG_W  = 5;
   localparam int STAT_W     = 2;
   localparam int FREE_OUT_W = 13;
   localparam int BLOCK_LIMIT = 4096;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
   localparam logic [STAT_W-1:0] ST_FREE    = 2'd3;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DATA   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_BLOCKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUPS       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IPG          = 2'd3;

   typedef struct packed {
      logic bm_we;
      logic cnt_we;
   } store_wr_type;

   // lowest clear bit of a bitmap word
   function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int k = WORD_BITS - 1; k >= 0; k--) begin
         if (!w[k]) r = BIT_W'(k);
      end
      return r;
   endfunction

endpackage

// File: src/grouped_bitmap_block_allocator_top.sv
// Grouped bitmap block allocator: request sequencer, config registers, result register.
//
//  port group  | dir | contents
//  req_*       | in  | tuser: action; tdata: block_number[11:0], inode_number[31:12]
//  rsp_*       | out | tdata: result_block[11:0], status[13:12], free_total[26:14]
//  csr_*       | in  | we, index, wdata: one config register per write
//
// Free: range check, read, test and result follow the transaction; a block out of range
// goes from the range check straight to the result. Allocate: goal, then a read and a test
// per bitmap word or empty group visited, then the claim and the result; a goal from the
// inode first waits on the divider, and with nothing free the request goes straight to the
// result. After reset a clearing pass over the GROUPS*BLOCKS_PER_GROUP/32 bitmap words
// (128 by default) runs before req_tready rises. A result waiting on rsp_tready does not
// stop the next request, but it holds in its last step until the result register is free.
module grouped_bitmap_block_allocator_top import gbba_pkg::*; #(
   parameter int BLOCKS_PER_GROUP = DEF_BLOCKS_PER_GROUP,
   parameter int GROUPS           = DEF_GROUPS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // block_number, inode_number
   input  logic                  req_tuser,   // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // result_block, status, free_total, zero pad
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int WPG    = BLOCKS_PER_GROUP / WORD_BITS;
   localparam int WORDS  = GROUPS * WPG;
   localparam int AW     = WORDS > 1 ? $clog2(WORDS) : 1;
   localparam int GW     = GROUPS > 1 ? $clog2(GROUPS) : 1;
   localparam int GIW    = $clog2(GROUPS + 1);
   localparam int WW     = WPG > 1 ? $clog2(WPG) : 1;
   localparam int CW     = $clog2(BLOCKS_PER_GROUP + 1);
   localparam int CAP    = GROUPS * BLOCKS_PER_GROUP;
   localparam int TW     = $clog2(CAP + 1);
   localparam int XW     = TW + 1;
   localparam int GOAL_W = INODE_W + CW + 1;
   localparam int PAD_W  = RSP_DATA_W - FREE_OUT_W - STAT_W - BLK_W;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_CLEAR = 4'd0;
   localparam logic [ST_W-1:0] S_IDLE  = 4'd1;
   localparam logic [ST_W-1:0] S_ALLOC = 4'd2;
   localparam logic [ST_W-1:0] S_DIV1  = 4'd3;
   localparam logic [ST_W-1:0] S_GOAL  = 4'd4;
   localparam logic [ST_W-1:0] S_RD    = 4'd6;
   localparam logic [ST_W-1:0] S_CHK   = 4'd7;
   localparam logic [ST_W-1:0] S_FOUND = 4'd8;
   localparam logic [ST_W-1:0] S_FREE  = 4'd9;
   localparam logic [ST_W-1:0] S_FRD   = 4'd11;
   localparam logic [ST_W-1:0] S_FCHK  = 4'd12;
   localparam logic [ST_W-1:0] S_DONE  = 4'd13;

   // config registers
   logic                  fdb_ff, fdb_in;
   logic [TBLK_W-1:0]     tblk_ff, tblk_in;
   logic [GRP_REG_W-1:0]  grp_ff, grp_in;
   logic [IPG_W-1:0]      ipg_ff, ipg_in;

   logic [ST_W-1:0]       state_ff, state_in;
   logic [AW-1:0]         sweep_ff, sweep_in;
   logic [TW-1:0]         total_free_ff, total_free_in;
   logic [BLK_W-1:0]      hint_ff, hint_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [BLK_W-1:0]      bn_ff, bn_in;
   logic [INODE_W-1:0]    ino_ff, ino_in;
   logic [GOAL_W-1:0]     goal_ff, goal_in;
   logic                  upd_ff, upd_in;
   logic [GW-1:0]         group_ff, group_in;
   logic [WW-1:0]         w_ff, w_in;
   logic [WW-1:0]         word_ff, word_in;
   logic [GIW-1:0]        i_ff, i_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [XW-1:0]         blk_ff, blk_in;
   logic [BLK_W-1:0]      res_blk_ff, res_blk_in;
   logic [STAT_W-1:0]     res_st_ff, res_st_in;

   logic [TBLK_W-1:0]     tb;
   logic [GIW-1:0]        gu;
   logic [GOAL_W-1:0]     g_sel;
   logic [BLK_W-1:0]      off;
   logic                  adv;

   logic                  div_start;
   logic [INODE_W-1:0]    div_a;
   logic [IPG_W-1:0]      div_b;
   logic                  div_done;
   logic [INODE_W-1:0]    div_q;

   store_wr_type          wr;
   logic [AW-1:0]         bm_addr;
   logic [WORD_BITS-1:0]  bm_wdata, bm_rdata;
   logic [GW-1:0]         cnt_addr;
   logic [CW-1:0]         cnt_wdata, cnt_rdata;

   assign tb = (int'(tblk_ff) > BLOCK_LIMIT) ? TBLK_W'(BLOCK_LIMIT) : tblk_ff;
   assign gu = (int'(grp_ff) > GROUPS) ? GIW'(GROUPS) : GIW'(grp_ff);

   assign bm_addr  = (state_ff == S_CLEAR) ? sweep_ff
                                           : AW'(group_ff) * AW'(WPG) + AW'(w_ff);
   assign cnt_addr = (state_ff == S_CLEAR) ? GW'(sweep_ff) : group_ff;

   always_comb begin
      fdb_in        = fdb_ff;
      tblk_in       = tblk_ff;
      grp_in        = grp_ff;
      ipg_in        = ipg_ff;
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      total_free_in = total_free_ff;
      hint_in       = hint_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      bn_in         = bn_ff;
      ino_in        = ino_ff;
      goal_in       = goal_ff;
      upd_in        = upd_ff;
      group_in      = group_ff;
      w_in          = w_ff;
      word_in       = word_ff;
      i_in          = i_ff;
      bit_in        = bit_ff;
      blk_in        = blk_ff;
      res_blk_in    = res_blk_ff;
      res_st_in     = res_st_ff;
      div_start     = 1'b0;
      div_a         = '0;
      div_b         = '0;
      wr            = '0;
      bm_wdata      = '0;
      cnt_wdata     = '0;
      g_sel         = goal_ff;
      off           = '0;
      adv           = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_DATA:   fdb_in  = csr_wdata[0];
            CSR_TOTAL_BLOCKS: tblk_in = csr_wdata[TBLK_W-1:0];
            CSR_GROUPS:       grp_in  = csr_wdata[GRP_REG_W-1:0];
            CSR_IPG:          ipg_in  = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr.bm_we  = 1'b1;
            wr.cnt_we = (int'(sweep_ff) < GROUPS);
            cnt_wdata = CW'(BLOCKS_PER_GROUP);
            if (sweep_ff == AW'(WORDS - 1)) state_in = S_IDLE;
            else sweep_in = sweep_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               bn_in      = req_tdata[BLK_W-1:0];
               ino_in     = req_tdata[BLK_W+INODE_W-1:BLK_W];
               res_blk_in = '0;
               res_st_in  = ST_OK;
               upd_in     = 1'b0;
               state_in   = (req_tuser == ACT_FREE) ? S_FREE : S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (total_free_ff == '0 || gu == '0) begin
               res_st_in = ST_NOSPACE;
               state_in  = S_DONE;
            end else if (bn_ff != '0) begin
               goal_in  = GOAL_W'(bn_ff);
               state_in = S_GOAL;
            end else if (ipg_ff != '0 && ino_ff != '0) begin
               div_start = 1'b1;
               div_a     = ino_ff - 1'b1;
               div_b     = ipg_ff;
               state_in  = S_DIV1;
            end else begin
               goal_in  = GOAL_W'(fdb_ff);
               state_in = S_GOAL;
            end
         end
         S_DIV1: begin
            if (div_done) begin
               goal_in  = GOAL_W'(div_q) * GOAL_W'(BLOCKS_PER_GROUP) + GOAL_W'(fdb_ff);
               state_in = S_GOAL;
            end
         end
         S_GOAL: begin
            // replace a bad or stale goal with the hint
            if (goal_ff >= GOAL_W'(tb) || (goal_ff < GOAL_W'(fdb_ff) && goal_ff != '0))
               g_sel = GOAL_W'(hint_ff);
            if (g_sel <= GOAL_W'(hint_ff)) begin
               g_sel  = GOAL_W'(hint_ff);
               upd_in = 1'b1;
            end
            off      = (g_sel >= GOAL_W'(fdb_ff)) ? BLK_W'(g_sel - GOAL_W'(fdb_ff)) : '0;
            word_in  = WW'((32'(off) % BLOCKS_PER_GROUP) / WORD_BITS);
            w_in     = WW'((32'(off) % BLOCKS_PER_GROUP) / WORD_BITS);
            group_in = (32'(off) / BLOCKS_PER_GROUP >= 32'(gu)) ? '0
                                                                : GW'(32'(off) / BLOCKS_PER_GROUP);
            i_in     = '0;
            state_in = S_RD;
         end
         S_RD: state_in = S_CHK;
         S_CHK: begin
            if (cnt_rdata == '0) begin
               adv = 1'b1;
            end else if (bm_rdata != '1) begin
               bit_in   = first_zero(bm_rdata);
               blk_in   = XW'(fdb_ff) + XW'(group_ff) * XW'(BLOCKS_PER_GROUP)
                        + XW'(w_ff) * XW'(WORD_BITS) + XW'(first_zero(bm_rdata));
               state_in = S_FOUND;
            end else if (w_ff == WW'(WPG - 1)) begin
               if (word_ff == '0) begin
                  res_st_in = ST_NOSPACE;
                  state_in  = S_DONE;
               end else begin
                  adv = 1'b1;
               end
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = S_RD;
            end
            if (adv) begin
               word_in = '0;
               w_in    = '0;
               if (i_ff == gu) begin
                  res_st_in = ST_NOSPACE;
                  state_in  = S_DONE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  group_in = (int'(group_ff) + 1 >= int'(gu)) ? '0 : group_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_FOUND: begin
            if (32'(blk_ff) >= 32'(tb)) begin
               res_st_in = ST_NOSPACE;
            end else begin
               wr.bm_we      = 1'b1;
               wr.cnt_we     = 1'b1;
               bm_wdata      = bm_rdata | (WORD_BITS'(1) << bit_ff);
               cnt_wdata     = cnt_rdata - 1'b1;
               total_free_in = (total_free_ff == '0) ? '0 : total_free_ff - 1'b1;
               if (upd_ff) hint_in = BLK_W'(blk_ff);
               res_blk_in    = BLK_W'(blk_ff);
               res_st_in     = ST_OK;
            end
            state_in = S_DONE;
         end
         S_FREE: begin
            off = bn_ff - BLK_W'(fdb_ff);
            if (32'(bn_ff) >= 32'(tb) || bn_ff < BLK_W'(fdb_ff) ||
                32'(off) / BLOCKS_PER_GROUP >= 32'(gu)) begin
               res_st_in = ST_RANGE;
               state_in  = S_DONE;
            end else begin
               group_in = GW'(32'(off) / BLOCKS_PER_GROUP);
               w_in     = WW'((32'(off) % BLOCKS_PER_GROUP) / WORD_BITS);
               bit_in   = off[BIT_W-1:0];
               state_in = S_FRD;
            end
         end
         S_FRD: state_in = S_FCHK;
         S_FCHK: begin
            if (!bm_rdata[bit_ff]) begin
               res_st_in = ST_FREE;
            end else begin
               wr.bm_we      = 1'b1;
               wr.cnt_we     = 1'b1;
               bm_wdata      = bm_rdata & ~(WORD_BITS'(1) << bit_ff);
               cnt_wdata     = (int'(cnt_rdata) < BLOCKS_PER_GROUP) ? cnt_rdata + 1'b1
                                                                    : cnt_rdata;
               total_free_in = (int'(total_free_ff) < CAP) ? total_free_ff + 1'b1
                                                           : total_free_ff;
               if (bn_ff < hint_ff) hint_in = bn_ff;
               res_st_in     = ST_OK;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PAD_W{1'b0}}, FREE_OUT_W'(total_free_ff), res_st_ff,
                               (res_st_ff == ST_OK) ? res_blk_ff : BLK_W'(0)};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fdb_ff        <= 1'b0;
         tblk_ff       <= TBLK_W'(BLOCK_LIMIT);
         grp_ff        <= GRP_REG_W'(16);
         ipg_ff        <= IPG_W'(256);
         state_ff      <= S_CLEAR;
         sweep_ff      <= '0;
         total_free_ff <= TW'(CAP);
         hint_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fdb_ff        <= fdb_in;
         tblk_ff       <= tblk_in;
         grp_ff        <= grp_in;
         ipg_ff        <= ipg_in;
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         total_free_ff <= total_free_in;
         hint_ff       <= hint_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      bn_ff       <= bn_in;
      ino_ff      <= ino_in;
      goal_ff     <= goal_in;
      upd_ff      <= upd_in;
      group_ff    <= group_in;
      w_ff        <= w_in;
      word_ff     <= word_in;
      i_ff        <= i_in;
      bit_ff      <= bit_in;
      blk_ff      <= blk_in;
      res_blk_ff  <= res_blk_in;
      res_st_ff   <= res_st_in;
   end

   gbba_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q)
   );

   gbba_store #(
      .BLOCKS_PER_GROUP (BLOCKS_PER_GROUP),
      .GROUPS           (GROUPS)
   ) u_store (
      .clock     (clock),
      .wr        (wr),
      .bm_addr   (bm_addr),
      .bm_wdata  (bm_wdata),
      .cnt_addr  (cnt_addr),
      .cnt_wdata (cnt_wdata),
      .bm_rdata  (bm_rdata),
      .cnt_rdata (cnt_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: src/gbba_div.sv
// Restoring divider, one quotient bit per cycle.
module gbba_div import gbba_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [INODE_W-1:0] dividend,
   input  logic [IPG_W-1:0]   divisor,
   output logic               done,
   output logic [INODE_W-1:0] quotient
);

   localparam int CNT_W = $clog2(INODE_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [INODE_W-1:0] quo_ff, quo_in;
   logic [IPG_W-1:0]   rem_ff, rem_in;
   logic [IPG_W-1:0]   dsr_ff, dsr_in;
   logic [IPG_W:0]     trial;
   logic               qbit;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[INODE_W-1]};
      qbit    = (trial >= {1'b0, dsr_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? IPG_W'(trial - {1'b0, dsr_ff}) : IPG_W'(trial);
         quo_in = {quo_ff[INODE_W-2:0], qbit};
         if (cnt_ff == CNT_W'(INODE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/gbba_store.sv
// Bitmap word memory and per-group free count memory, registered reads.
module gbba_store import gbba_pkg::*; #(
   parameter int BLOCKS_PER_GROUP = DEF_BLOCKS_PER_GROUP,
   parameter int GROUPS           = DEF_GROUPS
) (
   input  logic                                   clock,
   input  store_wr_type                           wr,
   input  logic [((GROUPS*(BLOCKS_PER_GROUP/WORD_BITS)) > 1 ?
                  $clog2(GROUPS*(BLOCKS_PER_GROUP/WORD_BITS)) : 1)-1:0] bm_addr,
   input  logic [WORD_BITS-1:0]                   bm_wdata,
   input  logic [(GROUPS > 1 ? $clog2(GROUPS) : 1)-1:0] cnt_addr,
   input  logic [$clog2(BLOCKS_PER_GROUP+1)-1:0]  cnt_wdata,
   output logic [WORD_BITS-1:0]                   bm_rdata,
   output logic [$clog2(BLOCKS_PER_GROUP+1)-1:0]  cnt_rdata
);

   localparam int WORDS = GROUPS * (BLOCKS_PER_GROUP / WORD_BITS);
   localparam int CW    = $clog2(BLOCKS_PER_GROUP + 1);

   logic [WORD_BITS-1:0] bm_mem [WORDS];
   logic [CW-1:0]        cnt_mem [GROUPS];
   logic [WORD_BITS-1:0] bm_rd_ff;
   logic [CW-1:0]        cnt_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.bm_we) bm_mem[bm_addr] <= bm_wdata;
      bm_rd_ff <= bm_mem[bm_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.cnt_we) cnt_mem[cnt_addr] <= cnt_wdata;
      cnt_rd_ff <= cnt_mem[cnt_addr];
   end

   assign bm_rdata  = bm_rd_ff;
   assign cnt_rdata = cnt_rd_ff;

endmodule

// File: src/gbba_checker.sv
// Port-level checks of the allocator, bound to the top level.
module gbba_checker import gbba_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a failed request never reports a block
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[BLK_W+STAT_W-1:BLK_W] != ST_OK |-> rsp_tdata[BLK_W-1:0] == '0)
      else $error("block reported on failure");

   // one request at a time: busy right after a transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // not ready during the cycle after reset: clearing pass runs
   a_clear: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("ready during clearing pass");

endmodule

bind grouped_bitmap_block_allocator_top gbba_checker u_gbba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
